[rtl/core/lias_pkg.sv]
`default_nettype none

package lias_pkg;

    // Default sizing
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int MODE_W     = 2;
    localparam int STEP_W     = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [MODE_W-1:0]    t_mode;

    localparam t_cfg_idx CFG_RATE_MODE = 2'd0;
    localparam t_cfg_idx CFG_STEREO    = 2'd1;
    localparam t_cfg_idx CFG_STEP      = 2'd2;

    localparam t_mode MODE_PASS = 2'd0;
    localparam t_mode MODE_HALF = 2'd1;
    localparam t_mode MODE_UP   = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'h10000;

endpackage

`default_nettype wire

[rtl/core/lias_lerp_unit.sv]
`default_nettype none

// Shared interpolation unit: one multiply per load, result finished from the
// registered product as base*ONE + (b-a)*f, truncated toward zero.
module lias_lerp_unit #(
    parameter int PHASE_FRAC_BITS = lias_pkg::PHASE_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS     = lias_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_load,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_a,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_b,
    input  wire logic        [PHASE_FRAC_BITS-1:0] i_frac,
    output logic signed      [SAMPLE_BITS-1:0]     o_res
);

    localparam int PFB = PHASE_FRAC_BITS;
    localparam int SB  = SAMPLE_BITS;
    localparam int NW  = SB + PFB + 2;

    localparam logic signed [NW-1:0] FRAC_MASK = NW'((64'd1 << PFB) - 64'd1);

    logic signed [SB:0]     w_diff;
    logic signed [PFB:0]    w_frac;
    logic signed [NW-1:0]   r_prod;
    logic signed [SB-1:0]   r_base;
    logic signed [NW-1:0]   w_num;
    logic signed [NW-1:0]   w_adj;

    assign w_diff = {i_b[SB-1], i_b} - {i_a[SB-1], i_a};
    assign w_frac = {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_diff * w_frac;
            r_base <= i_a;
        end
    end

    assign w_num = {{2{r_base[SB-1]}}, r_base, {PFB{1'b0}}} + r_prod;
    // bias negatives so the arithmetic shift truncates toward zero
    assign w_adj = w_num[NW-1] ? (w_num + FRAC_MASK) : w_num;
    assign o_res = w_adj[SB+PFB-1:PFB];

endmodule

`default_nettype wire

[rtl/core/linear_interp_audio_resampler.sv]
// Pass-through or halving: a result is registered when its beat is taken, and the push
// state loads it into the output register. Upsampling: an interpolated result takes two
// passes through the shared multiplier, a finish step and an output load; a repeated tail
// result takes a tail step and an output load. Beats are taken only in the idle state, so a
// new beat waits until all results of the last are loaded; m_axis_tready stalls hold push.
// Reset (synchronous, i_rst_n low): configuration registers to defaults, history cleared, next frame even.
`default_nettype none

module linear_interp_audio_resampler #(
    parameter int PHASE_FRAC_BITS = lias_pkg::PHASE_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS     = lias_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lias_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lias_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input frames
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [TDATA_W-1:0]                s_axis_tdata,  // in_left, in_right
    input  wire logic                              s_axis_tlast,  // in_last
    // output frames
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [TDATA_W-1:0]                     m_axis_tdata,  // out_left, out_right
    output logic                                   m_axis_tlast,  // run_last
    output logic                                   m_axis_tuser   // stream_end
);

    localparam int PFB = PHASE_FRAC_BITS;
    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = PFB + 2;
    localparam int SW  = (PW > lias_pkg::STEP_W) ? PW : lias_pkg::STEP_W;

    localparam logic [PW-1:0] ONE_X   = PW'(1) << PFB;
    localparam logic [SW-1:0] STEP_LO = SW'(1) << (PFB - 5);
    localparam logic [SW-1:0] STEP_HI = SW'(1) << PFB;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_L = 3'd1;
    localparam logic [2:0] ST_MUL_R = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_TAIL  = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    // configuration
    lias_pkg::t_mode                r_rate_mode;
    logic                           r_stereo;
    logic [lias_pkg::STEP_W-1:0]    r_step_ratio;

    // stream state
    logic signed [SB-1:0]  r_prev_l;
    logic signed [SB-1:0]  r_prev_r;
    logic                  r_have_prev;
    logic [PFB:0]          r_off;
    logic                  r_parity;

    // sequencer
    logic [2:0]            r_state;
    logic [2:0]            r_after;
    logic                  r_upd;
    logic                  r_last;
    logic [PFB:0]          r_pos;
    logic signed [SB-1:0]  r_cur_l;
    logic signed [SB-1:0]  r_cur_r;
    logic signed [SB-1:0]  r_res_l;
    logic signed [SB-1:0]  r_res_r;
    logic                  r_res_last;
    logic                  r_res_end;

    // output register
    logic                  r_m_valid;
    logic signed [SB-1:0]  r_out_l;
    logic signed [SB-1:0]  r_out_r;
    logic                  r_out_last;
    logic                  r_out_end;

    logic signed [SB-1:0]  w_in_l;
    logic signed [SB-1:0]  w_in_r;
    logic [SW-1:0]         w_step_ext;
    logic [PFB:0]          w_step;
    logic [PW-1:0]         w_pos_sum;
    logic [PW-1:0]         w_pos_wrap;
    logic                  w_wrap_tail;
    logic                  w_tail_more;
    logic                  w_off_fits;
    logic                  w_slot;
    logic                  w_unit_load;
    logic signed [SB-1:0]  w_unit_a;
    logic signed [SB-1:0]  w_unit_b;
    logic signed [SB-1:0]  w_lerp;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);

    assign w_in_l = s_axis_tdata[SB-1:0];
    assign w_in_r = r_stereo ? s_axis_tdata[2*SB-1:SB] : '0;

    // clamp step to [ONE/32, ONE]
    assign w_step_ext = SW'(r_step_ratio);
    always_comb begin
        if (w_step_ext < STEP_LO) begin
            w_step = STEP_LO[PFB:0];
        end else if (w_step_ext > STEP_HI) begin
            w_step = STEP_HI[PFB:0];
        end else begin
            w_step = w_step_ext[PFB:0];
        end
    end

    assign w_pos_sum   = PW'(r_pos) + PW'(w_step);
    assign w_pos_wrap  = w_pos_sum - ONE_X;
    assign w_wrap_tail = r_last && ((w_pos_wrap + PW'(w_step)) <= ONE_X);
    assign w_tail_more = (w_pos_sum + PW'(w_step)) <= ONE_X;
    assign w_off_fits  = (PW'(r_off) + PW'(w_step)) <= ONE_X;

    assign w_slot = !r_m_valid || m_axis_tready;

    assign w_unit_load = (r_state == ST_MUL_L) || (r_state == ST_MUL_R);
    assign w_unit_a    = (r_state == ST_MUL_L) ? r_prev_l : r_prev_r;
    assign w_unit_b    = (r_state == ST_MUL_L) ? r_cur_l  : r_cur_r;

    lias_lerp_unit #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_lerp (
        .i_clk  (i_clk),
        .i_load (w_unit_load),
        .i_a    (w_unit_a),
        .i_b    (w_unit_b),
        .i_frac (r_pos[PFB-1:0]),
        .o_res  (w_lerp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode  <= lias_pkg::MODE_PASS;
            r_stereo     <= 1'b1;
            r_step_ratio <= lias_pkg::STEP_RESET;
            r_prev_l     <= '0;
            r_prev_r     <= '0;
            r_have_prev  <= 1'b0;
            r_off        <= '0;
            r_parity     <= 1'b0;
            r_state      <= ST_IDLE;
            r_after      <= ST_IDLE;
            r_upd        <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lias_pkg::CFG_RATE_MODE: r_rate_mode  <= i_cfg_data[lias_pkg::MODE_W-1:0];
                    lias_pkg::CFG_STEREO:    r_stereo     <= i_cfg_data[0];
                    lias_pkg::CFG_STEP:      r_step_ratio <= i_cfg_data[lias_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end

            // drop the beat once taken; the push state reloads the register itself
            if (r_m_valid && m_axis_tready && (r_state != ST_PUSH)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cur_l <= w_in_l;
                        r_cur_r <= w_in_r;
                        r_last  <= s_axis_tlast;
                        r_upd   <= (r_rate_mode == lias_pkg::MODE_UP)
                                   && (r_have_prev || (s_axis_tlast && w_off_fits));
                        r_pos   <= r_off;
                        unique case (r_rate_mode)
                            lias_pkg::MODE_HALF: begin
                                if (!r_parity) begin
                                    r_prev_l    <= w_in_l;
                                    r_prev_r    <= w_in_r;
                                    r_have_prev <= !s_axis_tlast;
                                    r_parity    <= !s_axis_tlast;
                                end else begin
                                    r_res_l    <= r_prev_l;
                                    r_res_r    <= r_prev_r;
                                    r_res_last <= 1'b1;
                                    r_res_end  <= s_axis_tlast;
                                    r_after    <= ST_IDLE;
                                    r_state    <= ST_PUSH;
                                    r_parity   <= 1'b0;
                                    if (s_axis_tlast) begin
                                        r_have_prev <= 1'b0;
                                    end
                                end
                            end
                            lias_pkg::MODE_UP: begin
                                if (r_have_prev) begin
                                    r_state <= ST_MUL_L;
                                end else if (s_axis_tlast && w_off_fits) begin
                                    r_state <= ST_TAIL;
                                end else begin
                                    r_prev_l    <= w_in_l;
                                    r_prev_r    <= w_in_r;
                                    r_have_prev <= !s_axis_tlast;
                                end
                            end
                            default: begin
                                r_res_l     <= w_in_l;
                                r_res_r     <= w_in_r;
                                r_res_last  <= 1'b1;
                                r_res_end   <= s_axis_tlast;
                                r_after     <= ST_IDLE;
                                r_state     <= ST_PUSH;
                                r_prev_l    <= w_in_l;
                                r_prev_r    <= w_in_r;
                                r_have_prev <= !s_axis_tlast;
                            end
                        endcase
                        if (s_axis_tlast) begin
                            r_off <= '0;
                            if (r_rate_mode != lias_pkg::MODE_HALF) begin
                                r_parity <= 1'b0;
                            end
                        end
                    end
                end
                ST_MUL_L: begin
                    r_state <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    r_res_l <= w_lerp;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_res_r <= w_lerp;
                    r_state <= ST_PUSH;
                    if (w_pos_sum < ONE_X) begin
                        r_pos      <= w_pos_sum[PFB:0];
                        r_after    <= ST_MUL_L;
                        r_res_last <= 1'b0;
                        r_res_end  <= 1'b0;
                    end else begin
                        // crossed into the next source frame: continue with the tail or stop
                        r_pos      <= w_pos_wrap[PFB:0];
                        r_after    <= w_wrap_tail ? ST_TAIL : ST_IDLE;
                        r_res_last <= !w_wrap_tail;
                        r_res_end  <= !w_wrap_tail && r_last;
                    end
                end
                ST_TAIL: begin
                    // repeat the final frame
                    r_res_l    <= r_cur_l;
                    r_res_r    <= r_cur_r;
                    r_pos      <= w_pos_sum[PFB:0];
                    r_after    <= w_tail_more ? ST_TAIL : ST_IDLE;
                    r_res_last <= !w_tail_more;
                    r_res_end  <= !w_tail_more;
                    r_state    <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (w_slot) begin
                        r_m_valid  <= 1'b1;
                        r_out_l    <= r_res_l;
                        r_out_r    <= r_stereo ? r_res_r : '0;
                        r_out_last <= r_res_last;
                        r_out_end  <= r_res_end;
                        r_state    <= r_after;
                        if ((r_after == ST_IDLE) && r_upd) begin
                            r_prev_l    <= r_cur_l;
                            r_prev_r    <= r_cur_r;
                            r_have_prev <= !r_last;
                            r_off       <= r_last ? '0 : r_pos;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_r, r_out_l});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_end;

    // interpolation phase must stay inside one source interval
    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_L) |-> (PW'(r_pos) < ONE_X))
        else $error("interpolation phase out of range");

    // carried offset never reaches a whole frame
    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_off) < ONE_X)
        else $error("carried offset out of range");

    // end of buffer is always the last result of its frame
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("stream_end without run_last");

    // history is dropped once a final frame is fully handled
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && ($past(r_state) != ST_IDLE) && r_last) |-> !r_have_prev)
        else $error("history kept after final frame");

endmodule

`default_nettype wire

[tb/linear_interp_audio_resampler_tb.sv]
`default_nettype none

module linear_interp_audio_resampler_tb;

    localparam int SW           = lias_pkg::SAMPLE_BITS_DEF;
    localparam int FB           = lias_pkg::PHASE_FRAC_BITS_DEF;
    localparam int DW           = lias_pkg::CFG_DATA_W;
    localparam int TDW          = ((2 * SW + 7) / 8) * 8;
    localparam longint ONE      = longint'(1) << FB;
    localparam int BUSY_CYCLES  = 200;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 400;

    localparam lias_pkg::t_cfg_idx CFG_SPARE  = 2'd3;
    localparam lias_pkg::t_mode    MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          last;
    } t_frame;

    typedef struct {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          run_last;
        logic          stream_end;
    } t_out_frame;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [lias_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [DW-1:0]                   i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [TDW-1:0]                  s_axis_tdata  = '0;  // in_left, in_right
    logic                            s_axis_tlast  = 1'b0; // in_last
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [TDW-1:0]                  m_axis_tdata;        // out_left, out_right
    logic                            m_axis_tlast;        // run_last
    logic                            m_axis_tuser;        // stream_end

    linear_interp_audio_resampler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the block's registers and history
    lias_pkg::t_mode mode_r   = lias_pkg::MODE_PASS;
    logic          stereo_r = 1'b1;
    logic [16:0]   step_r   = lias_pkg::STEP_RESET;
    longint        hist_l   = 0;
    longint        hist_r   = 0;
    logic          hist_valid = 1'b0;
    longint        phase_off  = 0;
    logic          odd_frame  = 1'b0;

    t_frame        source_q[$];
    t_out_frame    resampled_q[$];
    t_frame        on_bus;

    int            frames_queued = 0;
    int            frames_taken  = 0;
    int            cfg_writes    = 0;
    int            out_beats     = 0;
    int            holds_done    = 0;
    int            err_count     = 0;
    int            src_gap       = 0;
    int            sink_gap      = 0;
    int            hold_cnt      = 0;
    int            hold_at       = 60;
    logic          no_idle       = 1'b0;
    logic          sink_hold     = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    function automatic longint blend(input longint a, input longint b, input longint f);
        return (a * (ONE - f) + b * f) / ONE;
    endfunction

    function automatic void emit(input longint l, input longint r);
        t_out_frame o;
        o.left       = l[SW-1:0];
        o.right      = stereo_r ? r[SW-1:0] : '0;
        o.run_last   = 1'b0;
        o.stream_end = 1'b0;
        resampled_q.push_back(o);
    endfunction

    // work out every output frame one source frame causes
    function automatic void resample_step(input t_frame f);
        longint     cl;
        longint     cr;
        longint     step;
        longint     pos;
        int         n0;
        t_out_frame tail;
        n0 = resampled_q.size();
        cl = longint'($signed(f.left));
        cr = stereo_r ? longint'($signed(f.right)) : 0;
        case (mode_r)
            lias_pkg::MODE_HALF: begin
                if (!odd_frame) begin
                    hist_l     = cl;
                    hist_r     = cr;
                    hist_valid = 1'b1;
                    odd_frame  = 1'b1;
                end else begin
                    emit(hist_l, hist_r);
                    odd_frame = 1'b0;
                end
            end
            lias_pkg::MODE_UP: begin
                step = longint'(step_r);
                if (step < (ONE >> 5))
                    step = ONE >> 5;
                if (step > ONE)
                    step = ONE;
                pos = phase_off;
                if (hist_valid) begin
                    while (pos < ONE) begin
                        emit(blend(hist_l, cl, pos), blend(hist_r, cr, pos));
                        pos += step;
                    end
                    pos -= ONE;
                end
                // repeat the final frame for positions past it
                if (f.last) begin
                    while (pos + step <= ONE) begin
                        emit(cl, cr);
                        pos += step;
                    end
                end
                phase_off  = pos;
                hist_l     = cl;
                hist_r     = cr;
                hist_valid = 1'b1;
            end
            default: begin
                emit(cl, cr);
                hist_l     = cl;
                hist_r     = cr;
                hist_valid = 1'b1;
            end
        endcase
        if (resampled_q.size() > n0) begin
            tail = resampled_q.pop_back();
            tail.run_last   = 1'b1;
            tail.stream_end = f.last;
            resampled_q.push_back(tail);
        end
        if (f.last) begin
            hist_valid = 1'b0;
            phase_off  = 0;
            odd_frame  = 1'b0;
        end
    endfunction

    // source side: one beat per item, random gap after each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                resample_step(on_bus);
                frames_taken++;
                src_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat
            end else if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (source_q.size() > 0) begin
                on_bus = source_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {on_bus.right, on_bus.left};
                s_axis_tlast  <= on_bus.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long output hold-off while the source keeps offering beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                out_beats++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                sink_hold <= (hold_cnt > 0);
            end else if (out_beats >= hold_at && s_axis_tvalid) begin
                hold_cnt = HOLD_CYCLES;
                hold_at  = out_beats + 2000;
                holds_done++;
                sink_hold <= 1'b1;
            end
        end
    end

    // sink side: check each beat against the oldest expected frame
    always @(posedge i_clk) begin
        t_out_frame want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (resampled_q.size() == 0) begin
                    report_mismatch("output beat with nothing expected");
                end else begin
                    want = resampled_q.pop_front();
                    if (m_axis_tdata[SW-1:0] !== want.left)
                        report_mismatch($sformatf("out_left got %0d want %0d",
                            $signed(m_axis_tdata[SW-1:0]), $signed(want.left)));
                    if (m_axis_tdata[2*SW-1:SW] !== want.right)
                        report_mismatch($sformatf("out_right got %0d want %0d",
                            $signed(m_axis_tdata[2*SW-1:SW]), $signed(want.right)));
                    if (m_axis_tlast !== want.run_last)
                        report_mismatch($sformatf("run_last got %b want %b",
                            m_axis_tlast, want.run_last));
                    if (m_axis_tuser !== want.stream_end)
                        report_mismatch($sformatf("stream_end got %b want %b",
                            m_axis_tuser, want.stream_end));
                end
                sink_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input lias_pkg::t_cfg_idx idx, input logic [DW-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lias_pkg::CFG_RATE_MODE: mode_r   = lias_pkg::t_mode'(data[lias_pkg::MODE_W-1:0]);
            lias_pkg::CFG_STEREO:    stereo_r = data[0];
            lias_pkg::CFG_STEP:      step_r   = data[lias_pkg::STEP_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic queue_frame(input logic [SW-1:0] l, input logic [SW-1:0] r,
                               input logic last);
        t_frame f;
        f.left  = l;
        f.right = r;
        f.last  = last;
        source_q.push_back(f);
        frames_queued++;
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return {1'b1, {(SW-1){1'b0}}};
            1:       return {1'b0, {(SW-1){1'b1}}};
            2:       return '0;
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic queue_buffer(input int len, input logic close);
        for (int k = 0; k < len; k++)
            queue_frame(rand_sample(), rand_sample(), close && (k == len - 1));
    endtask

    // wait until every frame is taken and every expected output seen
    task automatic settle();
        while (frames_taken != frames_queued || resampled_q.size() != 0)
            @(posedge i_clk);
        repeat (BUSY_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int               r;
        int               nbuf;
        int               len;
        logic [16:0]      stepv;
        lias_pkg::t_mode  pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: pass-through, stereo, sample extremes
        queue_frame(16'h8000, 16'h7fff, 1'b0);
        queue_frame(16'h7fff, 16'h8000, 1'b0);
        queue_frame(16'h0000, 16'h0000, 1'b1);
        queue_frame(16'hffff, 16'h0001, 1'b0);
        settle();

        // halving with a trailing unpaired frame, then a paired buffer
        write_reg(lias_pkg::CFG_RATE_MODE, DW'(lias_pkg::MODE_HALF));
        queue_buffer(5, 1'b1);
        queue_buffer(2, 1'b1);
        settle();

        // mono upsampling at the smallest step: most outputs per frame
        write_reg(lias_pkg::CFG_RATE_MODE, DW'(lias_pkg::MODE_UP));
        write_reg(lias_pkg::CFG_STEREO, DW'(1'b0));
        write_reg(lias_pkg::CFG_STEP, 17'd2048);
        queue_frame(16'h8000, 16'h1234, 1'b0);
        queue_frame(16'h7fff, 16'hedcb, 1'b0);
        queue_frame(16'h8000, 16'h5555, 1'b1);
        settle();

        write_reg(lias_pkg::CFG_STEREO, DW'(1'b1));
        write_reg(lias_pkg::CFG_STEP, 17'd65536);
        queue_buffer(3, 1'b1);
        settle();

        // unused mode value and out-of-range steps
        write_reg(lias_pkg::CFG_RATE_MODE, DW'(MODE_SPARE));
        write_reg(CFG_SPARE, 17'h1ffff);
        queue_buffer(2, 1'b0);
        settle();
        write_reg(lias_pkg::CFG_RATE_MODE, DW'(lias_pkg::MODE_UP));
        write_reg(lias_pkg::CFG_STEP, 17'h1ffff);
        queue_buffer(2, 1'b1);
        settle();
        write_reg(lias_pkg::CFG_STEP, 17'd0);
        queue_buffer(2, 1'b1);
        settle();

        // random phases; some end mid-buffer so the next mode inherits state
        while (frames_queued < RANDOM_ITEMS + 23) begin
            r = $urandom_range(0, 9);
            pick = r < 2 ? lias_pkg::MODE_PASS : r < 4 ? lias_pkg::MODE_HALF :
                   r < 9 ? lias_pkg::MODE_UP : MODE_SPARE;
            write_reg(lias_pkg::CFG_RATE_MODE, DW'(pick));
            if ($urandom_range(0, 1))
                write_reg(lias_pkg::CFG_STEREO, DW'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 15))
                    0:       stepv = 17'd2048;
                    1:       stepv = 17'd65536;
                    2:       stepv = 17'($urandom_range(0, 2047));
                    3:       stepv = 17'($urandom_range(65537, 131071));
                    default: stepv = 17'($urandom_range(8192, 65536));
                endcase
                write_reg(lias_pkg::CFG_STEP, stepv);
            end
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_SPARE, DW'($urandom_range(0, 131071)));
            no_idle = ($urandom_range(0, 3) == 0);
            nbuf = $urandom_range(1, 3);
            for (int b = 0; b < nbuf; b++) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 8);
                queue_buffer(len, $urandom_range(0, 7) != 0);
            end
            settle();
        end

        $display("run covered %0d source frames, %0d register writes, %0d output beats",
                 frames_taken, cfg_writes, out_beats);
        $display("modes pass, halve, upsample and spare; %0d long output hold-offs",
                 holds_done);
        if (err_count == 0)
            $display("[linear_interp_audio_resampler] OK");
        else
            $display("[linear_interp_audio_resampler] ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("[linear_interp_audio_resampler] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/lias_pkg.sv
rtl/core/lias_lerp_unit.sv
rtl/core/linear_interp_audio_resampler.sv
tb/linear_interp_audio_resampler_tb.sv
